// ===== design/joystick_event_conditioner_macros.svh =====
// Assertion macros shared by the joystick event conditioner.
`ifndef JOYSTICK_EVENT_CONDITIONER_MACROS_SVH
`define JOYSTICK_EVENT_CONDITIONER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JEC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("joystick event conditioner: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("joystick event conditioner: next-cycle check failed");

`endif

// ===== design/jec_pkg.sv =====
// Shared types and constants of the joystick event conditioner.
package jec_pkg;

  localparam int MAX_BUTTONS_DEF = 16;
  localparam int MAX_AXES_DEF    = 8;

  // Command index field covers the largest supported element count (64).
  localparam int CMD_IDX_W = 6;
  localparam int CMD_DEPTH = 2;

  localparam int VAL_W  = 16;
  localparam int DZ_W   = 15;
  localparam int GAIN_W = 20;
  localparam int TICK_W = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STICKY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM   = 3'd4;

  localparam logic [DZ_W-1:0]   DEAD_RST    = 15'd1638;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 20'd68985;
  localparam logic [TICK_W-1:0] PUBLISH_RST = 24'd16667;
  localparam logic [TICK_W-1:0] ACCUM_RST   = 24'd1000;

  localparam logic [7:0] EVT_BUTTON = 8'h01;
  localparam logic [7:0] EVT_AXIS   = 8'h02;
  localparam logic [7:0] EVT_INIT   = 8'h80;

  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  typedef struct packed {
    logic                    sticky_enable;
    logic [DZ_W-1:0]         deadband;
    logic [GAIN_W-1:0]       axis_gain;
    logic [TICK_W-1:0]       publish_ticks;
    logic [TICK_W-1:0]       accum_ticks;
  } cfg_t;

  typedef struct packed {
    logic                    store_en;
    logic                    is_axis;
    logic [CMD_IDX_W-1:0]    idx;
    logic                    level;
    logic signed [VAL_W-1:0] axis_val;
    logic                    publish;
  } cmd_t;

endpackage

// ===== design/joystick_event_conditioner.sv =====
// Top level of the joystick event conditioner: registers, front end, queue, publisher.
//
// Ticks and joystick events enter on the in_ channel; a tick that only counts
// down yields nothing. An event or timeout is taken, passes the front stage
// (dead zone and gain multiply), then waits in a two-entry command queue. The
// publisher pops a command only while idle; a publish run then passes a setup
// state and emits button_count + axis_count results (one when nothing is known
// yet), one per cycle while out_stall is low.
// Input is held off only when the front stage is full and the queue has no room.
// Registers (cfg_index): 0 sticky_enable, 1 deadband, 2 axis_gain,
// 3 publish_ticks, 4 accum_ticks; write them only while the block is idle.
`include "joystick_event_conditioner_macros.svh"
module joystick_event_conditioner import jec_pkg::*; #(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int MAX_AXES    = MAX_AXES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic [7:0]              in_event_type,
  input  logic [7:0]              in_event_number,
  input  logic signed [VAL_W-1:0] in_event_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [3:0]              out_element_index,
  output logic signed [VAL_W-1:0] out_element_value,
  output logic                    out_last_item
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t front_cmd;
  cmd_t fifo_cmd;
  logic front_cmd_valid;
  logic fifo_full;
  logic fifo_empty;
  logic cmd_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STICKY:  cfg_nxt.sticky_enable = cfg_wdata[0];
        CFG_DEAD:    cfg_nxt.deadband      = cfg_wdata[DZ_W-1:0];
        CFG_GAIN:    cfg_nxt.axis_gain     = cfg_wdata[GAIN_W-1:0];
        CFG_PUBLISH: cfg_nxt.publish_ticks = cfg_wdata[TICK_W-1:0];
        CFG_ACCUM:   cfg_nxt.accum_ticks   = cfg_wdata[TICK_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sticky_enable <= 1'b0;
      cfg_r.deadband      <= DEAD_RST;
      cfg_r.axis_gain     <= GAIN_RST;
      cfg_r.publish_ticks <= PUBLISH_RST;
      cfg_r.accum_ticks   <= ACCUM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jec_front #(
    .MAX_BUTTONS (MAX_BUTTONS),
    .MAX_AXES    (MAX_AXES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_event_type   (in_event_type),
    .in_event_number (in_event_number),
    .in_event_value  (in_event_value),
    .cmd_valid       (front_cmd_valid),
    .cmd             (front_cmd),
    .cmd_full        (fifo_full)
  );

  jec_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_cmd_valid),
    .push_data (front_cmd),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .pop_data  (fifo_cmd),
    .empty     (fifo_empty)
  );

  jec_back #(
    .MAX_BUTTONS (MAX_BUTTONS),
    .MAX_AXES    (MAX_AXES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .sticky_enable     (cfg_r.sticky_enable),
    .cmd_empty         (fifo_empty),
    .cmd               (fifo_cmd),
    .cmd_pop           (cmd_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_element_index (out_element_index),
    .out_element_value (out_element_value),
    .out_last_item     (out_last_item)
  );

  // A pending command that cannot drain must hold off new requests.
  `JEC_ASSERT_SAME(a_stage_blocked_stalls, front_cmd_valid && fifo_full, in_stall)
  `JEC_ASSERT_SAME(a_pop_not_empty, cmd_pop, !fifo_empty)
  `JEC_ASSERT_SAME(a_empty_marker_last, out_valid && (out_kind == KIND_EMPTY), out_last_item)

endmodule

// ===== design/jec_front.sv =====
// Front end: accepts items, runs the publish timers and conditions axis values.
module jec_front import jec_pkg::*; #(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int MAX_AXES    = MAX_AXES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic [7:0]              in_event_type,
  input  logic [7:0]              in_event_number,
  input  logic signed [VAL_W-1:0] in_event_value,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  logic                    cmd_full
);

  localparam logic [7:0] NB_LIM = 8'(MAX_BUTTONS);
  localparam logic [7:0] NA_LIM = 8'(MAX_AXES);
  localparam int PROD_W = VAL_W + 1 + GAIN_W + 1;

  logic [TICK_W-1:0] cd_r, cd_nxt;
  logic              armed_r, armed_nxt;
  logic              accum_r, accum_nxt;
  logic              hold_r, hold_nxt;

  logic                     fs_valid_r;
  logic                     fs_store_r;
  logic                     fs_axis_r;
  logic [CMD_IDX_W-1:0]     fs_idx_r;
  logic                     fs_level_r;
  logic signed [PROD_W-1:0] fs_prod_r;
  logic                     fs_pub_r;

  logic accept;
  logic is_btn;
  logic is_axis;
  logic do_store;
  logic pub;
  logic run_common;
  logic load;

  logic signed [VAL_W:0]    v_ext;
  logic signed [VAL_W:0]    d_ext;
  logic signed [VAL_W:0]    v_adj;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W:0]   neg;
  logic signed [PROD_W-16:0] q;
  logic signed [VAL_W-1:0]  sat;

  assign in_stall = fs_valid_r & cmd_full;
  assign accept   = in_valid & ~in_stall;

  assign is_btn  = ((in_event_type == EVT_BUTTON) || (in_event_type == (EVT_BUTTON | EVT_INIT)))
                   && (in_event_number < NB_LIM);
  assign is_axis = ((in_event_type == EVT_AXIS) || (in_event_type == (EVT_AXIS | EVT_INIT)))
                   && (in_event_number < NA_LIM);
  assign do_store = in_func & (is_btn | is_axis);

  // Timer and hold flags, in the order the publish decision needs them.
  always_comb begin
    cd_nxt     = cd_r;
    armed_nxt  = armed_r;
    accum_nxt  = accum_r;
    hold_nxt   = hold_r;
    pub        = 1'b0;
    run_common = 1'b0;
    if (accept) begin
      if (!in_func) begin
        if (cd_r > TICK_W'(1)) begin
          cd_nxt = cd_r - TICK_W'(1);
        end else begin
          run_common = 1'b1;
          if (armed_r) hold_nxt = 1'b0;
        end
      end else begin
        run_common = 1'b1;
        if (is_btn) begin
          hold_nxt = in_event_type[7];
        end else if (is_axis) begin
          hold_nxt = 1'b1;
        end
      end
      if (run_common) begin
        if (!hold_nxt) begin
          pub       = 1'b1;
          armed_nxt = 1'b0;
          accum_nxt = 1'b0;
        end
        if (!accum_nxt && hold_nxt) begin
          cd_nxt    = cfg.accum_ticks;
          accum_nxt = 1'b1;
          armed_nxt = 1'b1;
        end
        if (!armed_nxt) begin
          cd_nxt    = cfg.publish_ticks;
          armed_nxt = 1'b1;
        end
      end
    end
  end

  // Dead zone, then the gain product; the scaling finishes on the way out.
  always_comb begin
    v_ext = {in_event_value[VAL_W-1], in_event_value};
    d_ext = {2'b00, cfg.deadband};
    if (v_ext < -d_ext) begin
      v_adj = v_ext + d_ext;
    end else if (v_ext > d_ext) begin
      v_adj = v_ext - d_ext;
    end else begin
      v_adj = '0;
    end
    prod_nxt = PROD_W'(v_adj) * PROD_W'($signed({1'b0, cfg.axis_gain}));
  end

  assign load = accept & (do_store | pub);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r       <= '0;
      armed_r    <= 1'b0;
      accum_r    <= 1'b0;
      hold_r     <= 1'b0;
      fs_valid_r <= 1'b0;
    end else begin
      cd_r    <= cd_nxt;
      armed_r <= armed_nxt;
      accum_r <= accum_nxt;
      hold_r  <= hold_nxt;
      if (load) begin
        fs_valid_r <= 1'b1;
      end else if (!cmd_full) begin
        fs_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fs_store_r <= do_store;
      fs_axis_r  <= is_axis & ~is_btn;
      fs_idx_r   <= CMD_IDX_W'(in_event_number);
      fs_level_r <= (in_event_value != '0);
      fs_prod_r  <= prod_nxt;
      fs_pub_r   <= pub;
    end
  end

  // Negate, floor-shift by 16 and saturate to Q1.15.
  always_comb begin
    neg = -{fs_prod_r[PROD_W-1], fs_prod_r};
    q   = (PROD_W-15)'(neg >>> 16);
    if (q > (PROD_W-15)'(32767)) begin
      sat = 16'sh7fff;
    end else if (q < -(PROD_W-15)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = q[VAL_W-1:0];
    end
  end

  assign cmd_valid     = fs_valid_r;
  assign cmd.store_en  = fs_store_r;
  assign cmd.is_axis   = fs_axis_r;
  assign cmd.idx       = fs_idx_r;
  assign cmd.level     = fs_level_r;
  assign cmd.axis_val  = sat;
  assign cmd.publish   = fs_pub_r;

endmodule

// ===== design/jec_cmd_fifo.sv =====
// Two-entry command queue between the front end and the publisher.
module jec_cmd_fifo import jec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_DEPTH - 1);

  cmd_t             mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(CMD_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/jec_back.sv =====
// Back end: applies stores to the element state and emits publish runs.
module jec_back import jec_pkg::*; #(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int MAX_AXES    = MAX_AXES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    sticky_enable,
  input  logic                    cmd_empty,
  input  cmd_t                    cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [3:0]              out_element_index,
  output logic signed [VAL_W-1:0] out_element_value,
  output logic                    out_last_item
);

  localparam int BI_W  = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int AI_W  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int BC_W  = $clog2(MAX_BUTTONS + 1);
  localparam int AC_W  = $clog2(MAX_AXES + 1);
  localparam int PTR_W = $clog2(MAX_BUTTONS + MAX_AXES + 1);
  localparam int CI_W  = CMD_IDX_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]              state_r;
  logic [MAX_BUTTONS-1:0]  btn_now_r;
  logic [MAX_BUTTONS-1:0]  btn_prev_r;
  logic [MAX_BUTTONS-1:0]  btn_tog_r;
  logic signed [VAL_W-1:0] axis_r [MAX_AXES];
  logic [BC_W-1:0]         bc_r;
  logic [AC_W-1:0]         ac_r;
  logic [PTR_W-1:0]        ptr_r;

  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic [3:0]              out_index_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_last_r;

  logic [PTR_W-1:0]        total;
  logic [PTR_W-1:0]        aoff;
  logic [BI_W-1:0]         bidx;
  logic [AI_W-1:0]         aidx;
  logic                    bbit;
  logic                    out_load;
  logic [1:0]              kind_nxt;
  logic [3:0]              index_nxt;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    last_nxt;
  logic [CI_W-1:0]         idx_ext;

  assign cmd_pop  = (state_r == ST_IDLE) & ~cmd_empty;
  assign out_load = ~out_valid_r | ~out_stall;
  assign total    = PTR_W'(bc_r) + PTR_W'(ac_r);
  assign idx_ext  = {1'b0, cmd.idx};

  always_comb begin
    aoff = ptr_r - PTR_W'(bc_r);
    bidx = ptr_r[BI_W-1:0];
    aidx = aoff[AI_W-1:0];
    bbit = sticky_enable ? btn_tog_r[bidx] : btn_now_r[bidx];
    last_nxt = ((ptr_r + PTR_W'(1)) == total);
    if (total == '0) begin
      kind_nxt  = KIND_EMPTY;
      index_nxt = '0;
      value_nxt = '0;
      last_nxt  = 1'b1;
    end else if (ptr_r < PTR_W'(bc_r)) begin
      kind_nxt  = KIND_BUTTON;
      index_nxt = 4'(ptr_r);
      value_nxt = {{(VAL_W-1){1'b0}}, bbit};
    end else begin
      kind_nxt  = KIND_AXIS;
      index_nxt = 4'(aoff);
      value_nxt = axis_r[aidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      btn_now_r  <= '0;
      btn_prev_r <= '0;
      btn_tog_r  <= '0;
      for (int i = 0; i < MAX_AXES; i++) begin
        axis_r[i] <= '0;
      end
      bc_r  <= '0;
      ac_r  <= '0;
      ptr_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd.store_en) begin
              if (cmd.is_axis) begin
                axis_r[cmd.idx[AI_W-1:0]] <= cmd.axis_val;
                if (idx_ext >= CI_W'(ac_r)) ac_r <= AC_W'(idx_ext + CI_W'(1));
              end else begin
                btn_now_r[cmd.idx[BI_W-1:0]] <= cmd.level;
                if (idx_ext >= CI_W'(bc_r)) bc_r <= BC_W'(idx_ext + CI_W'(1));
              end
            end
            if (cmd.publish) state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Toggle on press edges over the known buttons before the run.
          if (sticky_enable) begin
            for (int i = 0; i < MAX_BUTTONS; i++) begin
              if (BC_W'(i) < bc_r) begin
                if (btn_now_r[i] && !btn_prev_r[i]) btn_tog_r[i] <= ~btn_tog_r[i];
                btn_prev_r[i] <= btn_now_r[i];
              end
            end
          end
          ptr_r   <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (out_load) begin
            if (last_nxt) begin
              state_r <= ST_IDLE;
            end else begin
              ptr_r <= ptr_r + PTR_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RUN) && out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RUN) && out_load) begin
      out_kind_r  <= kind_nxt;
      out_index_r <= index_nxt;
      out_value_r <= value_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_element_index = out_index_r;
  assign out_element_value = out_value_r;
  assign out_last_item     = out_last_r;

endmodule
